[rtl/ifla_pkg.sv]
// Package for the index free-list allocator: pool size, link and count widths,
// request and response types, and the request and status codes.
// Has no dependencies; the allocator top level imports it, ifla_ram does not.
package ifla_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LINK_W   = $clog2(CAPACITY + 1);
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [SLOT_W-1:0] release_id;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_index;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  in_use_count;
  } rsp_t;

endpackage

[rtl/index_free_list_allocator.sv]
// Top level of the index free-list allocator: request sequencer, list heads and
// output register around the link RAM. Depends on ifla_pkg and ifla_ram.
//
//   channel | signals                  | direction | payload
//   request | req_valid, req_ready    | in        | req  (ifla_pkg::req_t)
//   response| rsp_valid, rsp_ready    | out       | rsp  (ifla_pkg::rsp_t)
//
// After reset every link RAM entry is initialised before the first request is
// taken. An allocate passes through S_ALLOC and S_RESULT before its response is
// loaded; a full pool goes straight to S_RESULT. A release walks the in-use list
// at one link RAM read per cycle, over at most CAPACITY nodes. One request is in
// flight at a time; a new one is accepted while the previous response waits.
module index_free_list_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ifla_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ifla_pkg::rsp_t rsp
);

  import ifla_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ALLOC  = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FREE   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]         state, state_next;
  logic [ADDR_W-1:0]  init_idx, init_idx_next;
  logic [LINK_W-1:0]  free_head, free_head_next;
  logic [LINK_W-1:0]  used_head, used_head_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [LINK_W-1:0]  node, node_next;
  logic [LINK_W-1:0]  prev, prev_next;
  logic [LINK_W-1:0]  steps, steps_next;
  logic [SLOT_W-1:0]  rid, rid_next;
  rsp_t               res, res_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [LINK_W-1:0] ram_rdata;
  logic              load;

  ifla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_ready = (state == S_IDLE);
  assign load      = (state == S_RESULT) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next     = state;
    init_idx_next  = init_idx;
    free_head_next = free_head;
    used_head_next = used_head;
    count_next     = count;
    node_next      = node;
    prev_next      = prev;
    steps_next     = steps;
    rid_next       = rid;
    res_next       = res;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    unique case (state)
      S_INIT: begin
        ram_we        = 1'b1;
        ram_waddr     = init_idx;
        ram_wdata     = LINK_W'(init_idx) + LINK_W'(1);
        init_idx_next = init_idx + ADDR_W'(1);
        if (init_idx == ADDR_W'(CAPACITY - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          rid_next = req.release_id;
          if (req.req_type == REQ_ALLOC) begin
            if (free_head >= NULL_LINK) begin
              res_next.slot_index   = '0;
              res_next.status       = ST_FULL;
              res_next.in_use_count = count;
              state_next            = S_RESULT;
            end else begin
              ram_raddr  = free_head[ADDR_W-1:0];
              node_next  = free_head;
              state_next = S_ALLOC;
            end
          end else begin
            if (used_head >= NULL_LINK) begin
              res_next.slot_index   = req.release_id;
              res_next.status       = ST_NOT_USED;
              res_next.in_use_count = count;
              state_next            = S_RESULT;
            end else begin
              ram_raddr  = used_head[ADDR_W-1:0];
              node_next  = used_head;
              prev_next  = NULL_LINK;
              steps_next = '0;
              state_next = S_WALK;
            end
          end
        end
      end
      S_ALLOC: begin
        ram_we                = 1'b1;
        ram_waddr             = node[ADDR_W-1:0];
        ram_wdata             = used_head;
        free_head_next        = ram_rdata;
        used_head_next        = node;
        count_next            = count + COUNT_W'(1);
        res_next.slot_index   = SLOT_W'(node);
        res_next.status       = ST_OK;
        res_next.in_use_count = count + COUNT_W'(1);
        state_next            = S_RESULT;
      end
      S_WALK: begin
        if (node == LINK_W'(rid)) begin
          if (count == '0) begin
            res_next.slot_index   = rid;
            res_next.status       = ST_NOT_USED;
            res_next.in_use_count = count;
            state_next            = S_RESULT;
          end else begin
            if (prev >= NULL_LINK) begin
              used_head_next = ram_rdata;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = prev[ADDR_W-1:0];
              ram_wdata = ram_rdata;
            end
            state_next = S_FREE;
          end
        end else if (ram_rdata >= NULL_LINK || steps == LINK_W'(CAPACITY - 1)) begin
          res_next.slot_index   = rid;
          res_next.status       = ST_NOT_USED;
          res_next.in_use_count = count;
          state_next            = S_RESULT;
        end else begin
          ram_raddr  = ram_rdata[ADDR_W-1:0];
          prev_next  = node;
          node_next  = ram_rdata;
          steps_next = steps + LINK_W'(1);
        end
      end
      S_FREE: begin
        ram_we                = 1'b1;
        ram_waddr             = node[ADDR_W-1:0];
        ram_wdata             = free_head;
        free_head_next        = node;
        count_next            = count - COUNT_W'(1);
        res_next.slot_index   = rid;
        res_next.status       = ST_OK;
        res_next.in_use_count = count - COUNT_W'(1);
        state_next            = S_RESULT;
      end
      S_RESULT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_idx  <= '0;
      free_head <= '0;
      used_head <= NULL_LINK;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      init_idx  <= init_idx_next;
      free_head <= free_head_next;
      used_head <= used_head_next;
      count     <= count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    node  <= node_next;
    prev  <= prev_next;
    steps <= steps_next;
    rid   <= rid_next;
    res   <= res_next;
    if (load) begin
      rsp <= res;
    end
  end

endmodule

[rtl/ifla_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no package dependencies.
module ifla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
